// ===== rtl/tpt_state_variable_filter_macros.svh =====
// Assertion macros shared by the state variable filter RTL.
`ifndef TPT_STATE_VARIABLE_FILTER_MACROS_SVH
`define TPT_STATE_VARIABLE_FILTER_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising clock edge.
`define TPT_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tpt_svf: implication check failed");
// Next-cycle implication, checked on every rising clock edge.
`define TPT_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tpt_svf: next-cycle check failed");
`else
`define TPT_ASSERT_IMP(label, clk, rst, ante, cons)
`define TPT_ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== rtl/tpt_svf_pkg.sv =====
// Package with widths, codes, shared types and arithmetic helpers of the filter.
`timescale 1ns / 1ps

package tpt_svf_pkg;

   // Number of channels that keep filter state.
   localparam int CHANNELS = 2;

   localparam int SAMPLE_W   = 24;
   localparam int CHAN_W     = 4;
   localparam int COEF_W     = 18;
   localparam int MODE_W     = 2;
   localparam int STATE_W    = 32;
   localparam int COEF_FRAC  = 16;
   // Multiplier operand A holds z1, v3 or v1; v1 stays well inside 37 bits.
   localparam int OPA_W      = 37;
   localparam int PROD_W     = OPA_W + COEF_W + 1;
   // Intermediate results (v1, v2, highpass, new states) fit in 40 bits.
   localparam int WIDE_W     = 40;
   localparam int CH_IDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = COEF_W;

   // First channel number that bypasses the filter.
   localparam logic [CHAN_W:0] CHAN_LIMIT = (CHAN_W + 1)'(CHANNELS);

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_A1 = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_A2 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_A3 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DAMPING = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MODE    = 3'd4;

   // Output select codes.
   localparam logic [MODE_W-1:0] MODE_LOWPASS  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_HIGHPASS = 2'd1;
   localparam logic [MODE_W-1:0] MODE_BANDPASS = 2'd2;

   // Register reset values.
   localparam logic [COEF_W-1:0] COEF_A1_RESET = 18'd65536;
   localparam logic [COEF_W-1:0] COEF_A2_RESET = 18'd0;
   localparam logic [COEF_W-1:0] COEF_A3_RESET = 18'd0;
   localparam logic [COEF_W-1:0] DAMPING_RESET = 18'd131072;

   // Accumulator control of the shared multiply-accumulate unit.
   typedef struct packed {
      logic load;
      logic add;
   } mac_ctrl_type;

   // Write request into the integrator state bank.
   typedef struct packed {
      logic                       en;
      logic [CH_IDX_W-1:0]        idx;
      logic signed [STATE_W-1:0]  one;
      logic signed [STATE_W-1:0]  two;
   } bank_wr_type;

   // Round a coefficient product to nearest, ties toward plus infinity.
   function automatic logic signed [WIDE_W-1:0] round_frac(
      input logic signed [PROD_W-1:0] v);
      logic signed [PROD_W-1:0] t;
      t = v + $signed(PROD_W'(1) << (COEF_FRAC - 1));
      t = t >>> COEF_FRAC;
      return t[WIDE_W-1:0];
   endfunction

   // Saturate to the signed state range.
   function automatic logic signed [STATE_W-1:0] sat_state(
      input logic signed [WIDE_W-1:0] v);
      logic signed [WIDE_W-1:0] hi;
      logic signed [WIDE_W-1:0] lo;
      hi = {{(WIDE_W - STATE_W + 1){1'b0}}, {(STATE_W - 1){1'b1}}};
      lo = ~hi;
      if (v > hi) begin
         return hi[STATE_W-1:0];
      end else if (v < lo) begin
         return lo[STATE_W-1:0];
      end
      return v[STATE_W-1:0];
   endfunction

   // Saturate to the signed sample range.
   function automatic logic signed [SAMPLE_W-1:0] sat_sample(
      input logic signed [WIDE_W-1:0] v);
      logic signed [WIDE_W-1:0] hi;
      logic signed [WIDE_W-1:0] lo;
      hi = {{(WIDE_W - SAMPLE_W + 1){1'b0}}, {(SAMPLE_W - 1){1'b1}}};
      lo = ~hi;
      if (v > hi) begin
         return hi[SAMPLE_W-1:0];
      end else if (v < lo) begin
         return lo[SAMPLE_W-1:0];
      end
      return v[SAMPLE_W-1:0];
   endfunction

endpackage

// ===== rtl/tpt_svf_if.sv =====
// Valid/ready channel interfaces for filter requests and responses.
`timescale 1ns / 1ps

interface tpt_svf_req_if import tpt_svf_pkg::*; ();
   logic                        valid;
   logic                        ready;
   logic signed [SAMPLE_W-1:0]  sample_in;
   logic [CHAN_W-1:0]           chan;

   modport source (output valid, output sample_in, output chan, input ready);
   modport sink (input valid, input sample_in, input chan, output ready);
endinterface

interface tpt_svf_rsp_if import tpt_svf_pkg::*; ();
   logic                        valid;
   logic                        ready;
   logic signed [SAMPLE_W-1:0]  sample_out;
   logic [CHAN_W-1:0]           out_chan;

   modport source (output valid, output sample_out, output out_chan, input ready);
   modport sink (input valid, input sample_out, input out_chan, output ready);
endinterface

// ===== rtl/tpt_svf_mac.sv =====
// Shared multiplier with a registered product and an accumulator.
`timescale 1ns / 1ps

module tpt_svf_mac import tpt_svf_pkg::*; (
   input  logic                       clock,
   input  logic signed [OPA_W-1:0]    op_a,
   input  logic [COEF_W-1:0]          op_b,
   input  mac_ctrl_type               ctrl,
   output logic signed [PROD_W-1:0]   acc
);

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;
   logic signed [PROD_W-1:0] acc_ff;
   logic signed [PROD_W-1:0] acc_in;

   // Coefficients are unsigned; a zero sign bit keeps the product signed.
   assign prod_in = op_a * $signed({1'b0, op_b});

   // The accumulator either starts from the product, adds it or holds.
   always_comb begin
      acc_in = acc_ff;
      if (ctrl.load) begin
         acc_in = prod_ff;
      end else if (ctrl.add) begin
         acc_in = acc_ff + prod_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign acc = acc_ff;

endmodule

// ===== rtl/tpt_svf_bank.sv =====
// Per-channel integrator state bank, cleared at reset.
`timescale 1ns / 1ps

module tpt_svf_bank import tpt_svf_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [CH_IDX_W-1:0]        rd_idx,
   input  bank_wr_type                wr,
   output logic signed [STATE_W-1:0]  rd_one,
   output logic signed [STATE_W-1:0]  rd_two
);

   logic signed [STATE_W-1:0] one_ff [CHANNELS];
   logic signed [STATE_W-1:0] two_ff [CHANNELS];

   // Reset zeroes every channel; otherwise a write updates one channel.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            one_ff[i] <= '0;
            two_ff[i] <= '0;
         end
      end else if (wr.en) begin
         one_ff[wr.idx] <= wr.one;
         two_ff[wr.idx] <= wr.two;
      end
   end

   assign rd_one = one_ff[rd_idx];
   assign rd_two = two_ff[rd_idx];

endmodule

// ===== rtl/tpt_state_variable_filter.sv =====
// Top level of the multi-channel trapezoidal state variable filter.
`timescale 1ns / 1ps
`include "tpt_state_variable_filter_macros.svh"

// Trapezoidal state variable filter for CHANNELS channels. Each request carries
// a Q1.23 sample and a channel number; the response returns the lowpass,
// highpass or bandpass output selected by the mode register, saturated to
// 24 bits, with the channel echoed. Channels at or above CHANNELS pass the
// sample through and leave all state alone. A filtered item passes a state
// read, the multiply steps and the output register before the block takes
// the next request; a bypassed item goes straight to the output register.
// One shared 37 x 19 bit multiplier runs the five coefficient products of a
// step one after another. The output register waits for a free response
// slot. Requests are not taken while an item is in work. Coefficients are
// unsigned Q2.16 and must only be written while the block is idle.
module tpt_state_variable_filter import tpt_svf_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   tpt_svf_req_if.sink                req_bus,
   tpt_svf_rsp_if.source              rsp_bus,
   input  logic                       csr_wr_en,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_wdata
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_LOAD,
      S_MUL,
      S_OUT
   } state_type;

   // Steps of the multiply sequence.
   localparam logic [2:0] STEP_A1_Z1 = 3'd0;
   localparam logic [2:0] STEP_A2_V3 = 3'd1;
   localparam logic [2:0] STEP_A2_Z1 = 3'd2;
   localparam logic [2:0] STEP_A3_V3 = 3'd3;
   localparam logic [2:0] STEP_K_V1  = 3'd4;
   localparam logic [2:0] STEP_V2    = 3'd5;
   localparam logic [2:0] STEP_LAST  = 3'd6;

   state_type                   state_ff, state_in;
   logic [2:0]                  step_ff, step_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0]  rsp_sample_ff, rsp_sample_in;
   logic [CHAN_W-1:0]           rsp_chan_ff, rsp_chan_in;

   logic signed [SAMPLE_W-1:0]  x_ff, x_in;
   logic [CHAN_W-1:0]           chan_ff, chan_in;
   logic signed [STATE_W-1:0]   z1_ff, z1_in;
   logic signed [STATE_W-1:0]   z2_ff, z2_in;
   logic signed [STATE_W:0]     v3_ff, v3_in;
   logic signed [WIDE_W-1:0]    v1_ff, v1_in;
   logic signed [WIDE_W-1:0]    v2_ff, v2_in;
   logic signed [SAMPLE_W-1:0]  res_ff, res_in;

   logic [COEF_W-1:0]           coef_a1_ff, coef_a2_ff, coef_a3_ff, damping_ff;
   logic [MODE_W-1:0]           mode_ff;

   logic                        accept;
   logic                        bypass_in;
   logic                        rsp_free;
   logic signed [OPA_W-1:0]     op_a;
   logic [COEF_W-1:0]           op_b;
   mac_ctrl_type                mac_ctrl;
   logic signed [PROD_W-1:0]    acc;
   bank_wr_type                 bank_wr;
   logic signed [STATE_W-1:0]   bank_one, bank_two;
   logic signed [WIDE_W-1:0]    hp_wide, one_wide, two_wide;
   logic signed [SAMPLE_W-1:0]  lp_sat, bp_sat, hp_sat, sel_sat;

   // Configuration registers; writes to unknown indexes are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         coef_a1_ff <= COEF_A1_RESET;
         coef_a2_ff <= COEF_A2_RESET;
         coef_a3_ff <= COEF_A3_RESET;
         damping_ff <= DAMPING_RESET;
         mode_ff    <= MODE_LOWPASS;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_COEF_A1: coef_a1_ff <= csr_wdata;
            CSR_COEF_A2: coef_a2_ff <= csr_wdata;
            CSR_COEF_A3: coef_a3_ff <= csr_wdata;
            CSR_DAMPING: damping_ff <= csr_wdata;
            CSR_MODE:    mode_ff    <= csr_wdata[MODE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign req_bus.ready = (state_ff == S_IDLE);
   assign accept        = req_bus.valid && req_bus.ready;
   assign bypass_in     = ({1'b0, req_bus.chan} >= CHAN_LIMIT);
   assign rsp_free      = !rsp_valid_ff || rsp_bus.ready;

   // Operand select for the shared multiplier, one product per step.
   always_comb begin
      unique case (step_ff)
         STEP_A1_Z1: begin
            op_a = OPA_W'(z1_ff);
            op_b = coef_a1_ff;
         end
         STEP_A2_V3: begin
            op_a = OPA_W'(v3_ff);
            op_b = coef_a2_ff;
         end
         STEP_A2_Z1: begin
            op_a = OPA_W'(z1_ff);
            op_b = coef_a2_ff;
         end
         STEP_A3_V3: begin
            op_a = OPA_W'(v3_ff);
            op_b = coef_a3_ff;
         end
         default: begin
            op_a = $signed(v1_ff[OPA_W-1:0]);
            op_b = damping_ff;
         end
      endcase
   end

   // The product of step n reaches the accumulator in step n + 1.
   always_comb begin
      mac_ctrl.load = 1'b0;
      mac_ctrl.add  = 1'b0;
      if (state_ff == S_MUL) begin
         mac_ctrl.load = (step_ff == STEP_A2_V3) || (step_ff == STEP_A3_V3)
                         || (step_ff == STEP_V2);
         mac_ctrl.add  = (step_ff == STEP_A2_Z1) || (step_ff == STEP_K_V1);
      end
   end

   tpt_svf_mac u_mac (
      .clock (clock),
      .op_a  (op_a),
      .op_b  (op_b),
      .ctrl  (mac_ctrl),
      .acc   (acc)
   );

   tpt_svf_bank u_bank (
      .clock  (clock),
      .reset  (reset),
      .rd_idx (chan_ff[CH_IDX_W-1:0]),
      .wr     (bank_wr),
      .rd_one (bank_one),
      .rd_two (bank_two)
   );

   // Final outputs and new integrator states, valid in the last step.
   always_comb begin
      hp_wide  = WIDE_W'(x_ff) - round_frac(acc) - v2_ff;
      one_wide = (v1_ff <<< 1) - WIDE_W'(z1_ff);
      two_wide = (v2_ff <<< 1) - WIDE_W'(z2_ff);
      lp_sat   = sat_sample(v2_ff);
      bp_sat   = sat_sample(v1_ff);
      hp_sat   = sat_sample(hp_wide);
      unique case (mode_ff)
         MODE_HIGHPASS: sel_sat = hp_sat;
         MODE_BANDPASS: sel_sat = bp_sat;
         default:       sel_sat = lp_sat;
      endcase
   end

   assign bank_wr.en  = (state_ff == S_MUL) && (step_ff == STEP_LAST);
   assign bank_wr.idx = chan_ff[CH_IDX_W-1:0];
   assign bank_wr.one = sat_state(one_wide);
   assign bank_wr.two = sat_state(two_wide);

   // Sequencer: take a request, read state, run the multiply steps, respond.
   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_sample_in = rsp_sample_ff;
      rsp_chan_in   = rsp_chan_ff;
      x_in          = x_ff;
      chan_in       = chan_ff;
      z1_in         = z1_ff;
      z2_in         = z2_ff;
      v3_in         = v3_ff;
      v1_in         = v1_ff;
      v2_in         = v2_ff;
      res_in        = res_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               x_in    = req_bus.sample_in;
               chan_in = req_bus.chan;
               res_in  = req_bus.sample_in;
               state_in = bypass_in ? S_OUT : S_LOAD;
            end
         end
         S_LOAD: begin
            z1_in    = bank_one;
            z2_in    = bank_two;
            v3_in    = (STATE_W + 1)'(x_ff) - (STATE_W + 1)'(bank_two);
            step_in  = STEP_A1_Z1;
            state_in = S_MUL;
         end
         S_MUL: begin
            step_in = step_ff + 3'd1;
            if (step_ff == STEP_A3_V3) begin
               v1_in = round_frac(acc);
            end
            if (step_ff == STEP_V2) begin
               v2_in = WIDE_W'(z2_ff) + round_frac(acc);
            end
            if (step_ff == STEP_LAST) begin
               res_in   = sel_sat;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_sample_in = res_ff;
               rsp_chan_in   = chan_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= STEP_A1_Z1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_sample_ff <= rsp_sample_in;
      rsp_chan_ff   <= rsp_chan_in;
      x_ff          <= x_in;
      chan_ff       <= chan_in;
      z1_ff         <= z1_in;
      z2_ff         <= z2_in;
      v3_ff         <= v3_in;
      v1_ff         <= v1_in;
      v2_ff         <= v2_in;
      res_ff        <= res_in;
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.sample_out = rsp_sample_ff;
   assign rsp_bus.out_chan   = rsp_chan_ff;

   // State is only written at the end of a filtered item.
   `TPT_ASSERT_IMP(a_bank_wr_last, clock, reset, bank_wr.en, state_ff == S_MUL && step_ff == STEP_LAST)
   // A bypassed request goes straight to the response stage.
   `TPT_ASSERT_NXT(a_bypass_direct, clock, reset, accept && bypass_in, state_ff == S_OUT)
   // A response only appears out of the response stage.
   `TPT_ASSERT_NXT(a_rsp_from_out, clock, reset, state_ff != S_OUT, !$rose(rsp_valid_ff))
   // Reset leaves the block idle with no response pending.
   `TPT_ASSERT_NXT(a_reset_idle, clock, 1'b0, reset, state_ff == S_IDLE && !rsp_valid_ff)

endmodule
